// ===== design/longest_prefix_match_lookup_defines.svh =====
// Assertion macros shared by the lookup design.
`ifndef LONGEST_PREFIX_MATCH_LOOKUP_DEFINES_SVH
`define LONGEST_PREFIX_MATCH_LOOKUP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LPM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lookup assertion failed");

// Next-cycle implication, disabled while reset is high.
`define LPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lookup assertion failed");

`endif

// ===== design/lpm_pkg.sv =====
`timescale 1ns / 1ps

package lpm_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int INDEX_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int ADDR_BITS   = 32;
   localparam int LEN_W       = 6;
   localparam int PORT_W      = 4;

   localparam logic [PORT_W-1:0] DEFAULT_PORT_RESET = PORT_W'(2);

   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   typedef struct packed {
      logic [ADDR_BITS-1:0] prefix;
      logic [LEN_W-1:0]     length;
      logic [PORT_W-1:0]    port;
   } entry_type;

   typedef struct packed {
      logic               en;
      logic [INDEX_W-1:0] index;
      entry_type          entry;
      logic               enable;
   } table_wr_type;

   typedef struct packed {
      entry_type entry;
      logic      valid;
   } table_rd_type;

endpackage

// ===== design/longest_prefix_match_lookup.sv =====
`timescale 1ns / 1ps
//  Channel   Ports                          Direction
//  req       req_valid / req_ready          in   write or lookup item
//  rsp       rsp_valid / rsp_ready          out  lookup result
//  csr       csr_wr_en / csr_wr_data        in   default port, no wait
//
//  A write item produces no result.
//  A lookup item reads one table slot per cycle through the single read port of the
//  table memory, then passes through ST_DRAIN and ST_RESP before its result is loaded.
//  Reset empties the table at once and sets the default port to 2.
//  A pending result waiting on rsp_ready does not block writes; a finished lookup
//  waits until the output register is free.

`include "longest_prefix_match_lookup_defines.svh"

module longest_prefix_match_lookup (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [5:0]  req_entry_index,
   input  logic [31:0] req_entry_prefix,
   input  logic [5:0]  req_entry_length,
   input  logic [3:0]  req_entry_port,
   input  logic        req_entry_enable,
   input  logic [31:0] req_dest_addr,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_out_port,
   output logic        rsp_matched,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_RESP  = 4'b1000
   } state_type;

   localparam logic [lpm_pkg::INDEX_W-1:0] LAST_INDEX =
      lpm_pkg::INDEX_W'(lpm_pkg::TABLE_DEPTH - 1);

   state_type                         state_ff, state_in;
   logic [lpm_pkg::INDEX_W-1:0]       cnt_ff, cnt_in;
   logic                              cmp_en_ff, cmp_en_in;
   logic [lpm_pkg::ADDR_BITS-1:0]     addr_ff, addr_in;
   logic                              found_ff, found_in;
   logic [lpm_pkg::LEN_W-1:0]         best_len_ff, best_len_in;
   logic [lpm_pkg::PORT_W-1:0]        best_port_ff, best_port_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [lpm_pkg::PORT_W-1:0]        rsp_port_ff, rsp_port_in;
   logic                              rsp_matched_ff, rsp_matched_in;
   logic [lpm_pkg::PORT_W-1:0]        default_port_ff, default_port_in;

   logic                              req_xfer;
   logic                              load_rsp;
   logic                              hit;
   logic [lpm_pkg::LEN_W-1:0]         len_clamped;
   logic [lpm_pkg::ADDR_BITS-1:0]     mask;
   lpm_pkg::table_wr_type             wr;
   lpm_pkg::table_rd_type             rd_data;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign load_rsp  = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);

   assign len_clamped = (req_entry_length > lpm_pkg::LEN_W'(lpm_pkg::ADDR_BITS)) ?
                        lpm_pkg::LEN_W'(lpm_pkg::ADDR_BITS) : req_entry_length;

   always_comb begin
      wr.en           = req_xfer && (req_func == lpm_pkg::FUNC_WRITE) &&
                        (32'(req_entry_index) < 32'(lpm_pkg::TABLE_DEPTH));
      wr.index        = lpm_pkg::INDEX_W'(req_entry_index);
      wr.entry.prefix = req_entry_prefix;
      wr.entry.length = len_clamped;
      wr.entry.port   = req_entry_port;
      wr.enable       = req_entry_enable;
   end

   lpm_table u_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_en   (state_ff == ST_SCAN),
      .rd_addr (cnt_ff),
      .rd_data (rd_data)
   );

   // Shift right by the length, so a length of 32 clears everything and 0 keeps it.
   assign mask = ~({lpm_pkg::ADDR_BITS{1'b1}} >> rd_data.entry.length);
   assign hit  = cmp_en_ff && rd_data.valid &&
                 (((rd_data.entry.prefix ^ addr_ff) & mask) == '0);

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      cmp_en_in       = 1'b0;
      addr_in         = addr_ff;
      found_in        = found_ff;
      best_len_in     = best_len_ff;
      best_port_in    = best_port_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_port_in     = rsp_port_ff;
      rsp_matched_in  = rsp_matched_ff;
      default_port_in = csr_wr_en ? csr_wr_data : default_port_ff;

      // Strictly longer wins, so among equal lengths the lower slot stays.
      if (hit && (!found_ff || (rd_data.entry.length > best_len_ff))) begin
         found_in     = 1'b1;
         best_len_in  = rd_data.entry.length;
         best_port_in = rd_data.entry.port;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_func == lpm_pkg::FUNC_LOOKUP)) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
               addr_in  = req_dest_addr;
               found_in = 1'b0;
            end
         end
         ST_SCAN: begin
            cmp_en_in = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == LAST_INDEX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (load_rsp) begin
               state_in       = ST_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_port_in    = found_ff ? best_port_ff : default_port_ff;
               rsp_matched_in = found_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         cnt_ff          <= '0;
         cmp_en_ff       <= 1'b0;
         found_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         default_port_ff <= lpm_pkg::DEFAULT_PORT_RESET;
      end else begin
         state_ff        <= state_in;
         cnt_ff          <= cnt_in;
         cmp_en_ff       <= cmp_en_in;
         found_ff        <= found_in;
         rsp_valid_ff    <= rsp_valid_in;
         default_port_ff <= default_port_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff        <= addr_in;
      best_len_ff    <= best_len_in;
      best_port_ff   <= best_port_in;
      rsp_port_ff    <= rsp_port_in;
      rsp_matched_ff <= rsp_matched_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_port = rsp_port_ff;
   assign rsp_matched  = rsp_matched_ff;

   `LPM_ASSERT_SAME(a_busy_not_ready, clock, reset, state_ff != ST_IDLE, !req_ready)
   `LPM_ASSERT_NEXT(a_lookup_starts, clock, reset,
      req_xfer && (req_func == lpm_pkg::FUNC_LOOKUP),
      (state_ff == ST_SCAN) && (cnt_ff == '0) && !found_ff)
   `LPM_ASSERT_NEXT(a_result_loaded, clock, reset, load_rsp,
      rsp_valid_ff && (rsp_matched_ff == $past(found_ff)) && (state_ff == ST_IDLE))
   `LPM_ASSERT_SAME(a_compare_window, clock, reset, cmp_en_ff,
      (state_ff == ST_SCAN) || (state_ff == ST_DRAIN))

endmodule

// ===== design/lpm_table.sv =====
`timescale 1ns / 1ps

module lpm_table (
   input  logic                          clock,
   input  logic                          reset,
   input  lpm_pkg::table_wr_type         wr,
   input  logic                          rd_en,
   input  logic [lpm_pkg::INDEX_W-1:0]   rd_addr,
   output lpm_pkg::table_rd_type         rd_data
);

   lpm_pkg::entry_type                   mem [lpm_pkg::TABLE_DEPTH];
   logic [lpm_pkg::TABLE_DEPTH-1:0]      valid_ff;
   lpm_pkg::entry_type                   rd_entry_ff;
   logic                                 rd_valid_ff;

   // Entry fields need no reset; an entry counts only while its valid bit is set.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.index] <= wr.entry;
      end
      if (rd_en) begin
         rd_entry_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.index] <= wr.enable;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data.entry = rd_entry_ff;
   assign rd_data.valid = rd_valid_ff;

endmodule
